/* design/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// shared types and constants of the relative strength index block
// ----------------------------------------------------------------------------
package rsi_pkg;

    // configuration register
    localparam int          PERIOD_W       = 11;
    localparam logic [10:0] PERIOD_RESET   = 11'd14;

    // ratio stage: averages brought below 2^48 before scaling
    localparam int          RATIO_BITS     = 48;
    localparam int          SUM_W          = RATIO_BITS + 1;
    localparam int          RATIO_NUM_BITS = 63;

    // result format, 100.0 in q7.8
    localparam int          RSI_W          = 15;
    localparam logic [14:0] FULL_SCALE     = 15'd25600;
    // 25600 = 25 << 10, and 25 = 16 + 8 + 1
    localparam int          SCALE_SH       = 10;

    // divider run length counter, enough for 64 iterations
    localparam int          DIV_CNT_W      = 7;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* design/rsi_if.sv */
// ----------------------------------------------------------------------------
// rsi_if
// valid/ready channels for price words and index words
// ----------------------------------------------------------------------------
interface rsi_in_if #(
    parameter int PRICE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] close_price;
    logic                  start_series;

    modport source (output valid, output close_price, output start_series, input ready);
    modport sink   (input valid, input close_price, input start_series, output ready);
endinterface

interface rsi_out_if;
    logic                        valid;
    logic                        ready;
    logic [rsi_pkg::RSI_W-1:0]   rsi_value;
    logic                        rsi_valid;

    modport source (output valid, output rsi_value, output rsi_valid, input ready);
    modport sink   (input valid, input rsi_value, input rsi_valid, output ready);
endinterface

/* design/relative_strength_index_top.sv */
// ----------------------------------------------------------------------------
// relative_strength_index_top
// wilder relative strength index over a stream of closing prices
// ----------------------------------------------------------------------------
// One price word in gives one index word out, in order. The first price of a
// series (after reset or with start_series set) only primes the history and
// returns an invalid zero. The next price seeds a gain and a loss average with
// its change, each later one updates them with 1/period smoothing, and once
// period changes are seen the index 100*gain/(gain+loss) comes out in q7.8
// with rsi_valid set (an invalid zero if both averages are zero). The block
// takes one word at a time: all divisions run through a single restoring
// divider that yields one quotient bit per cycle. A series start goes straight
// to the output; the seeding change skips the smoothing; a smoothed change
// runs one division per average; once the period is complete, the averages
// are shifted down to fit, scaled and divided for the ratio. A finished word
// waits for the output register. The period register may be written only
// while idle and takes effect from the next price word.
// ----------------------------------------------------------------------------
module relative_strength_index_top #(
    parameter int PRICE_BITS    = 32,
    parameter int AVG_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_period_we,
    input  logic [rsi_pkg::PERIOD_W-1:0]  i_period_wdata,
    rsi_in_if.sink                        i_in,
    rsi_out_if.source                     o_out
);

    // average width, smoothing dividend width, shared divider widths
    localparam int AW    = PRICE_BITS + AVG_FRAC_BITS;
    localparam int SM_W  = AW + 1;
    localparam int NUM_W = (SM_W > rsi_pkg::RATIO_NUM_BITS) ? SM_W : rsi_pkg::RATIO_NUM_BITS;
    localparam int DEN_W = rsi_pkg::SUM_W;
    localparam int PW    = rsi_pkg::PERIOD_W;
    localparam int RQ    = rsi_pkg::RSI_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHG,
        ST_SG,
        ST_WG,
        ST_SL,
        ST_WL,
        ST_COUNT,
        ST_NORM,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_RS,
        ST_WR,
        ST_DONE
    } t_state;

    t_state                r_state;

    // configuration and series history
    logic [PW-1:0]         r_period;
    logic [PRICE_BITS-1:0] r_last_price;
    logic                  r_have_price;
    logic [AW-1:0]         r_avg_gain;
    logic [AW-1:0]         r_avg_loss;
    logic                  r_seeded;
    logic [PW-1:0]         r_count;

    // word being worked on
    logic [PRICE_BITS-1:0] r_price;
    logic                  r_start;
    logic [AW-1:0]         r_gain;
    logic [AW-1:0]         r_loss;
    logic                  r_neg;
    logic [AW-1:0]         r_g;
    logic [AW-1:0]         r_l;
    logic [DEN_W-1:0]      r_gn;
    logic [DEN_W-1:0]      r_sum;
    logic [NUM_W-1:0]      r_acc;
    logic [RQ-1:0]         r_res_value;
    logic                  r_res_flag;

    // output register
    logic                  r_out_valid;
    logic [RQ-1:0]         r_out_value;
    logic                  r_out_flag;

    // shared divider hookup
    rsi_pkg::t_div_ctl     w_div_ctl;
    rsi_pkg::t_div_sts     w_div_sts;
    logic [DEN_W-1:0]      w_div_rem;
    logic [NUM_W-1:0]      w_div_num;
    logic [DEN_W-1:0]      w_div_den;
    logic [NUM_W-1:0]      w_div_quo;

    logic [PW-1:0]         w_p;
    logic                  w_up;
    logic [PRICE_BITS-1:0] w_diff;
    logic [AW-1:0]         w_chg;
    logic [AW-1:0]         w_x;
    logic [AW-1:0]         w_avg;
    logic                  w_ge;
    logic [AW-1:0]         w_absd;
    logic [SM_W-1:0]       w_dividend;
    logic [PW-1:0]         w_cnt_next;
    logic                  w_big;
    logic [DEN_W-1:0]      w_sum;
    logic [AW-1:0]         w_step;
    logic                  w_in_fire;
    logic                  w_out_load;

    // period of zero behaves as one
    assign w_p = (r_period == '0) ? PW'(1) : r_period;

    // price change scaled into the average format
    assign w_up   = r_price > r_last_price;
    assign w_diff = w_up ? (r_price - r_last_price) : (r_last_price - r_price);
    assign w_chg  = {w_diff, {AVG_FRAC_BITS{1'b0}}};

    // smoothing operand select: loss side in its start state, gain otherwise
    assign w_x        = (r_state == ST_SL) ? r_loss : r_gain;
    assign w_avg      = (r_state == ST_SL) ? r_avg_loss : r_avg_gain;
    assign w_ge       = w_x >= w_avg;
    assign w_absd     = w_ge ? (w_x - w_avg) : (w_avg - w_x);
    // round to nearest, ties away from zero
    assign w_dividend = SM_W'(w_absd) + SM_W'(w_p >> 1);
    assign w_step     = AW'(w_div_quo);

    // change count saturates at the period in force
    assign w_cnt_next = (r_count < w_p) ? (r_count + PW'(1)) : r_count;

    // either average too wide for the ratio stage
    assign w_big = ((r_g >> rsi_pkg::RATIO_BITS) != '0) || ((r_l >> rsi_pkg::RATIO_BITS) != '0);
    assign w_sum = DEN_W'(r_g) + DEN_W'(r_l);

    // divider inputs: smoothing runs the whole dividend, the ratio starts with
    // its upper part preloaded since the quotient stays below 2^15
    always_comb begin
        w_div_ctl.start = (r_state == ST_SG) || (r_state == ST_SL) || (r_state == ST_RS);
        if (r_state == ST_RS) begin
            w_div_ctl.count = rsi_pkg::DIV_CNT_W'(RQ);
            w_div_rem       = DEN_W'(r_acc >> RQ);
            w_div_num       = r_acc << (NUM_W - RQ);
            w_div_den       = r_sum;
        end else begin
            w_div_ctl.count = rsi_pkg::DIV_CNT_W'(SM_W);
            w_div_rem       = '0;
            w_div_num       = NUM_W'(w_dividend) << (NUM_W - SM_W);
            w_div_den       = DEN_W'(w_p);
        end
    end

    rsi_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_rem_init (w_div_rem),
        .i_num      (w_div_num),
        .i_den      (w_div_den),
        .o_sts      (w_div_sts),
        .o_quo      (w_div_quo)
    );

    // input taken whenever the sequencer is idle, even with a word still
    // waiting at the output
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;

    // finished word moves into the output register once it is free
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_period     <= rsi_pkg::PERIOD_RESET;
            r_have_price <= 1'b0;
            r_seeded     <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_period_we) begin
                r_period <= i_period_wdata;
            end
            if (r_out_valid && o_out.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_price <= i_in.close_price;
                        r_start <= i_in.start_series;
                        r_state <= ST_CHG;
                    end
                end

                ST_CHG: begin
                    r_res_value <= '0;
                    r_res_flag  <= 1'b0;
                    if (r_start || !r_have_price) begin
                        // new series: prime the history only
                        r_last_price <= r_price;
                        r_have_price <= 1'b1;
                        r_avg_gain   <= '0;
                        r_avg_loss   <= '0;
                        r_seeded     <= 1'b0;
                        r_count      <= '0;
                        r_state      <= ST_DONE;
                    end else begin
                        r_last_price <= r_price;
                        r_gain       <= w_up ? w_chg : '0;
                        r_loss       <= w_up ? '0 : w_chg;
                        if (!r_seeded) begin
                            r_avg_gain <= w_up ? w_chg : '0;
                            r_avg_loss <= w_up ? '0 : w_chg;
                            r_seeded   <= 1'b1;
                            r_state    <= ST_COUNT;
                        end else begin
                            r_state <= ST_SG;
                        end
                    end
                end

                ST_SG: begin
                    r_neg   <= !w_ge;
                    r_state <= ST_WG;
                end

                ST_WG: begin
                    if (w_div_sts.done) begin
                        r_avg_gain <= r_neg ? (r_avg_gain - w_step) : (r_avg_gain + w_step);
                        r_state    <= ST_SL;
                    end
                end

                ST_SL: begin
                    r_neg   <= !w_ge;
                    r_state <= ST_WL;
                end

                ST_WL: begin
                    if (w_div_sts.done) begin
                        r_avg_loss <= r_neg ? (r_avg_loss - w_step) : (r_avg_loss + w_step);
                        r_state    <= ST_COUNT;
                    end
                end

                ST_COUNT: begin
                    r_count <= w_cnt_next;
                    if (w_cnt_next < w_p) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_g     <= r_avg_gain;
                        r_l     <= r_avg_loss;
                        r_state <= ST_NORM;
                    end
                end

                ST_NORM: begin
                    // one joint right shift a cycle until both fit
                    if (w_big) begin
                        r_g <= r_g >> 1;
                        r_l <= r_l >> 1;
                    end else if (w_sum == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_gn    <= DEN_W'(r_g);
                        r_sum   <= w_sum;
                        r_state <= ST_M1;
                    end
                end

                ST_M1: begin
                    r_acc   <= (NUM_W'(r_gn) << 4) + (NUM_W'(r_gn) << 3);
                    r_state <= ST_M2;
                end

                ST_M2: begin
                    r_acc   <= r_acc + NUM_W'(r_gn);
                    r_state <= ST_M3;
                end

                ST_M3: begin
                    // 25600*g plus half the sum, rounds the ratio to nearest
                    r_acc   <= (r_acc << rsi_pkg::SCALE_SH) + NUM_W'(r_sum >> 1);
                    r_state <= ST_RS;
                end

                ST_RS: begin
                    r_state <= ST_WR;
                end

                ST_WR: begin
                    if (w_div_sts.done) begin
                        r_res_value <= w_div_quo[RQ-1:0];
                        r_res_flag  <= 1'b1;
                        r_state     <= ST_DONE;
                    end
                end

                ST_DONE: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_flag  <= r_res_flag;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.rsi_value = r_out_value;
    assign o_out.rsi_valid = r_out_flag;

`ifndef SYNTHESIS
    // an accepted word always starts the sequencer
    a_fire_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == ST_CHG))
        else $error("accepted word did not start processing");

    // the shared divider is never restarted mid-run
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.start |-> !w_div_sts.busy)
        else $error("divider started while busy");

    // a divider result only shows up while a wait state expects it
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> ((r_state == ST_WG) || (r_state == ST_WL) || (r_state == ST_WR)))
        else $error("divider finished outside a wait state");

    // index never above full scale
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) && w_div_sts.done |-> (w_div_quo[RQ-1:0] <= rsi_pkg::FULL_SCALE))
        else $error("index above full scale");

    // an invalid index word carries zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_flag |-> (r_out_value == '0))
        else $error("invalid word with nonzero value");
`endif

endmodule

/* design/rsi_div.sv */
// ----------------------------------------------------------------------------
// rsi_div
// restoring divider, one quotient bit per cycle, preloadable partial remainder
// ----------------------------------------------------------------------------
module rsi_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 49
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsi_pkg::t_div_ctl i_ctl,
    input  logic [DEN_W-1:0]  i_rem_init,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output rsi_pkg::t_div_sts o_sts,
    output logic [NUM_W-1:0]  o_quo
);

    logic [DEN_W-1:0]              r_rem;
    logic [NUM_W-1:0]              r_num;
    logic [DEN_W-1:0]              r_den;
    logic [rsi_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [DEN_W+1:0]              w_trial;

    // shift in next dividend bit and try to take the divisor off
    assign w_trial = {1'b0, r_rem, r_num[NUM_W-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_rem  <= i_rem_init;
                r_num  <= i_num;
                r_den  <= i_den;
                r_cnt  <= i_ctl.count;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_trial[DEN_W+1]) begin
                    r_rem <= w_trial[DEN_W-1:0];
                end else begin
                    r_rem <= {r_rem[DEN_W-2:0], r_num[NUM_W-1]};
                end
                // quotient bits enter at the bottom as dividend bits leave the top
                r_num <= {r_num[NUM_W-2:0], ~w_trial[DEN_W+1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rsi_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_num;

endmodule

/* tb/relative_strength_index_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_strength_index_top_tb
// self-checking bench for the wilder relative strength index block
// ----------------------------------------------------------------------------
// A scripted run covers series starts, period extremes, one-sided moves, flat
// prices and period changes within a series. Random phases follow, each with
// its own period and idling pattern. Every accepted price word is run through
// a local model of the gain and loss averages, and each index word that comes
// out is compared with the oldest expected word.
// ----------------------------------------------------------------------------
module relative_strength_index_top_tb;

    localparam int PRICE_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int AVG_W          = PRICE_BITS + FRAC_BITS;
    // time for a smoothed change to come through, normalizing shifts included
    localparam int ITEM_CYCLES    = 200;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 50;
    localparam int SCRIPT_ROWS    = 21;
    localparam int PHASES         = 11;
    localparam int HOLD_PHASE     = 4;
    localparam int DRAIN_PHASE    = 5;

    // per phase: period register value and number of price words
    localparam int PH_PERIOD [PHASES] = '{3, 1, 14, 2, 0, 7, 31, 200, 1024, 2047, 5};
    localparam int PH_ITEMS  [PHASES] = '{200, 150, 200, 150, 100, 200, 200, 260, 60, 60, 170};

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [rsi_pkg::RSI_W-1:0] value;
        logic                      valid;
    } t_rsi_word;

    // one scripted price word, with an optional period write ahead of it
    typedef struct {
        bit                           wr;
        logic [rsi_pkg::PERIOD_W-1:0] per;
        logic [PRICE_BITS-1:0]        price;
        bit                           start;
        bit                           typed;
        logic [rsi_pkg::RSI_W-1:0]    value;
        bit                           valid;
    } t_script_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_period_we;
    logic [rsi_pkg::PERIOD_W-1:0] i_period_wdata;

    rsi_in_if #(.PRICE_BITS(PRICE_BITS)) price_ch ();
    rsi_out_if                           index_ch ();

    relative_strength_index_top #(
        .PRICE_BITS    (PRICE_BITS),
        .AVG_FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_period_we    (i_period_we),
        .i_period_wdata (i_period_wdata),
        .i_in           (price_ch),
        .o_out          (index_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // local copy of the block state
    logic [rsi_pkg::PERIOD_W-1:0] period_setting = rsi_pkg::PERIOD_RESET;
    logic [PRICE_BITS-1:0]        prev_close     = '0;
    bit                           have_close     = 1'b0;
    logic [AVG_W-1:0]             gain_avg       = '0;
    logic [AVG_W-1:0]             loss_avg       = '0;
    bit                           avg_primed     = 1'b0;
    logic [rsi_pkg::PERIOD_W-1:0] changes_seen   = '0;

    t_rsi_word             pending_index [$];
    int                    mismatches     = 0;
    int                    words_seen     = 0;

    // idling knobs: the send gap is read by the stimulus, the rest by the receiver process
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    hold_requests  = 0;

    t_script_row           price_script [SCRIPT_ROWS];

    task automatic report_mismatch(input string what);
        mismatches++;
        // keep the log short on a badly broken build
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at index word %0d: %s", words_seen, what);
    endtask

    // one smoothing step, rounding to nearest with ties away from zero
    function automatic logic [AVG_W-1:0] wilder_smooth(input logic [AVG_W-1:0] avg,
                                                       input logic [AVG_W-1:0] x,
                                                       input logic [63:0]      p);
        logic [63:0] step;
        if (x >= avg) begin
            step = (64'(x - avg) + (p >> 1)) / p;
            return avg + step[AVG_W-1:0];
        end
        step = (64'(avg - x) + (p >> 1)) / p;
        return avg - step[AVG_W-1:0];
    endfunction

    // advance the local state by one price word and return its index word
    function automatic t_rsi_word predict_index(input logic [PRICE_BITS-1:0] price,
                                                input bit                    start);
        t_rsi_word                    word;
        logic [rsi_pkg::PERIOD_W-1:0] p;
        logic [AVG_W-1:0]             gain_x;
        logic [AVG_W-1:0]             loss_x;
        logic [63:0]                  g;
        logic [63:0]                  s;
        logic [63:0]                  q;
        word = '0;
        // a zero period behaves as one
        p = (period_setting == '0) ? rsi_pkg::PERIOD_W'(1) : period_setting;

        // first price of a series only primes the history
        if (start || !have_close) begin
            prev_close   = price;
            have_close   = 1'b1;
            gain_avg     = '0;
            loss_avg     = '0;
            avg_primed   = 1'b0;
            changes_seen = '0;
            return word;
        end

        gain_x = '0;
        loss_x = '0;
        if (price > prev_close)
            gain_x = {price - prev_close, {FRAC_BITS{1'b0}}};
        else
            loss_x = {prev_close - price, {FRAC_BITS{1'b0}}};
        prev_close = price;

        if (!avg_primed) begin
            gain_avg   = gain_x;
            loss_avg   = loss_x;
            avg_primed = 1'b1;
        end else begin
            gain_avg = wilder_smooth(gain_avg, gain_x, 64'(p));
            loss_avg = wilder_smooth(loss_avg, loss_x, 64'(p));
        end

        if (changes_seen < p)
            changes_seen = changes_seen + 1'b1;
        if (changes_seen < p)
            return word;

        // averages are 48 bits wide, so no normalizing shift applies here
        g = 64'(gain_avg);
        s = g + 64'(loss_avg);
        if (s == 64'd0)
            return word;
        q          = (64'(rsi_pkg::FULL_SCALE) * g + (s >> 1)) / s;
        word.value = q[rsi_pkg::RSI_W-1:0];
        word.valid = 1'b1;
        return word;
    endfunction

    // offer one price word, hold it until taken, then log what should come out
    task automatic send_price(input logic [PRICE_BITS-1:0] price, input bit start,
                              input bit typed, input t_rsi_word typed_word);
        t_rsi_word want;
        price_ch.valid        <= 1'b1;
        price_ch.close_price  <= price;
        price_ch.start_series <= start;
        do @(posedge i_clk); while (!price_ch.ready);
        want = predict_index(price, start);
        pending_index.push_back(typed ? typed_word : want);
    endtask

    // write the period once the block has drained
    task automatic load_period(input logic [rsi_pkg::PERIOD_W-1:0] value);
        price_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_index.size() != 0);
        repeat (2) @(posedge i_clk);
        i_period_we    <= 1'b1;
        i_period_wdata <= value;
        @(posedge i_clk);
        i_period_we    <= 1'b0;
        period_setting = value;
    endtask

    // index word checker
    always @(posedge i_clk) begin
        t_rsi_word want;
        if (i_rst_n && index_ch.valid && index_ch.ready) begin
            if (pending_index.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %0d valid %0b",
                                          index_ch.rsi_value, index_ch.rsi_valid));
            end else begin
                want = pending_index.pop_front();
                if (index_ch.rsi_value !== want.value)
                    report_mismatch($sformatf("rsi_value %0d, expected %0d",
                                              index_ch.rsi_value, want.value));
                if (index_ch.rsi_valid !== want.valid)
                    report_mismatch($sformatf("rsi_valid %0b, expected %0b",
                                              index_ch.rsi_valid, want.valid));
            end
            words_seen++;
        end
    end

    // receiver: random stall runs, plus a long hold when asked for
    initial begin : receiver
        int run_left;
        int hold_left;
        int holds_served;
        run_left     = 0;
        hold_left    = 0;
        holds_served = 0;
        index_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
                run_left  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                index_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(99) < recv_stall_pct) begin
                // stall and ready runs share one length range
                index_ch.ready <= 1'b0;
                run_left = $urandom_range(0, 20);
            end else begin
                index_ch.ready <= 1'b1;
                run_left = $urandom_range(0, 20);
            end
        end
    end

    // watchdog: too long without any word moving ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((price_ch.valid && price_ch.ready) || (index_ch.valid && index_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_rsi_word             typed_word;
        t_idle_mode            mode;
        logic [PRICE_BITS-1:0] walk_price;
        logic [PRICE_BITS-1:0] mag;
        logic [PRICE_BITS-1:0] price;
        bit                    start;
        int                    series_left;
        int                    eff_period;
        int                    scale;
        int                    dir_mode;

        i_rst_n               <= 1'b0;
        i_period_we           <= 1'b0;
        i_period_wdata        <= '0;
        price_ch.valid        <= 1'b0;
        price_ch.close_price  <= '0;
        price_ch.start_series <= 1'b0;

        // scripted words: typed expectations where they are obvious
        price_script = '{
            // first word after reset, then too few changes at the reset period
            '{1'b0, 11'd0,    32'd100,          1'b0, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'd200,          1'b0, 1'b1, 15'd0,      1'b0},
            // series restart in the middle of a series
            '{1'b0, 11'd0,    32'd150,          1'b1, 1'b1, 15'd0,      1'b0},
            // period one: full-range rise, full-range fall, then flat
            '{1'b1, 11'd1,    32'd0,            1'b1, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'hFFFF_FFFF,    1'b0, 1'b1, rsi_pkg::FULL_SCALE, 1'b1},
            '{1'b0, 11'd0,    32'd0,            1'b0, 1'b1, 15'd0,      1'b1},
            '{1'b0, 11'd0,    32'd0,            1'b0, 1'b1, 15'd0,      1'b0},
            // zero period acts as one
            '{1'b1, 11'd0,    32'd5,            1'b1, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'd7,            1'b0, 1'b1, rsi_pkg::FULL_SCALE, 1'b1},
            '{1'b0, 11'd0,    32'd3,            1'b0, 1'b1, 15'd0,      1'b1},
            // period two: smoothing, rounding ties, and period changes mid-series
            '{1'b1, 11'd2,    32'd100,          1'b1, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'd101,          1'b0, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'd100,          1'b0, 1'b0, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'd100,          1'b0, 1'b0, 15'd0,      1'b0},
            '{1'b1, 11'd3,    32'd104,          1'b0, 1'b0, 15'd0,      1'b0},
            '{1'b1, 11'd1,    32'd90,           1'b0, 1'b0, 15'd0,      1'b0},
            // largest nominal period and largest register value
            '{1'b1, 11'd1024, 32'h8000_0000,    1'b1, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'h7FFF_FFFF,    1'b0, 1'b1, 15'd0,      1'b0},
            '{1'b1, 11'd2047, 32'hAAAA_AAAA,    1'b1, 1'b1, 15'd0,      1'b0},
            '{1'b0, 11'd0,    32'h5555_5555,    1'b0, 1'b1, 15'd0,      1'b0},
            '{1'b1, 11'd14,   32'd1000,         1'b1, 1'b1, 15'd0,      1'b0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (price_script[r]) begin
            if (price_script[r].wr)
                load_period(price_script[r].per);
            typed_word = '{price_script[r].value, price_script[r].valid};
            send_price(price_script[r].price, price_script[r].start,
                       price_script[r].typed, typed_word);
        end

        // random phases: mostly coherent series with random content
        walk_price  = '0;
        scale       = 0;
        dir_mode    = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            load_period(rsi_pkg::PERIOD_W'(PH_PERIOD[ph]));
            mode = t_idle_mode'(ph % 4);
            case (mode)
                IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SEND: begin send_gap_pct = 68; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 68; end
                default:   begin send_gap_pct = 35; recv_stall_pct = 35; end
            endcase
            eff_period  = (PH_PERIOD[ph] == 0) ? 1 : PH_PERIOD[ph];
            series_left = 0;

            // back-pressure: the receiver sits on its ready while words keep coming
            if (ph == HOLD_PHASE)
                hold_requests++;

            for (int n = 0; n < PH_ITEMS[ph]; n++) begin
                // sender stops and waits for every pending index word
                if (ph == DRAIN_PHASE && n == PH_ITEMS[ph] / 2) begin
                    price_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (pending_index.size() != 0);
                end else if ($urandom_range(99) < send_gap_pct) begin
                    price_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 160)) @(posedge i_clk);
                end

                if (series_left == 0) begin
                    // new series: fresh price, step size and trend
                    start       = 1'b1;
                    series_left = $urandom_range(1, 3 * eff_period + 8);
                    walk_price  = $urandom();
                    dir_mode    = $urandom_range(2);
                    case ($urandom_range(5))
                        0:       scale = 0;
                        1:       scale = 1;
                        2:       scale = 4;
                        3:       scale = 12;
                        4:       scale = 20;
                        default: scale = 31;
                    endcase
                    price = walk_price;
                end else begin
                    // stray restarts and wild jumps as noise
                    start = ($urandom_range(99) < 2);
                    if ($urandom_range(19) == 0) begin
                        walk_price = $urandom();
                    end else begin
                        mag = $urandom() & ((32'd1 << scale) - 32'd1);
                        if (dir_mode == 1 || (dir_mode == 0 && $urandom_range(1) == 1))
                            walk_price = walk_price + mag;
                        else
                            walk_price = walk_price - mag;
                    end
                    price = walk_price;
                end
                series_left--;
                send_price(price, start, 1'b0, '0);
            end
        end

        // drain and give a stray extra word time to show up
        price_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_index.size() != 0);
        repeat (ITEM_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
design/rsi_pkg.sv
design/rsi_if.sv
design/rsi_div.sv
design/relative_strength_index_top.sv
tb/relative_strength_index_top_tb.sv
